[rtl/afd_pkg.sv]
// Shared types and constants for the altimeter frame deframer.
package afd_pkg;

    localparam int BYTE_W     = 8;
    localparam int OFFSET_W   = 16;
    localparam int HEIGHT_W   = 17;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int HELD       = 5;
    localparam int FILL_W     = 3;

    localparam logic [FILL_W-1:0] FILL_FULL = 3'd5;

    localparam logic [CFG_IDX_W-1:0] REG_SYNC_BYTE     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_VALID_CODE    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT_OFFSET = 2'd2;

    localparam logic [BYTE_W-1:0]   SYNC_BYTE_RST     = 8'h7E;
    localparam logic [BYTE_W-1:0]   VALID_CODE_RST    = 8'h80;
    localparam logic [OFFSET_W-1:0] HEIGHT_OFFSET_RST = 16'd3000;

    typedef struct packed {
        logic [BYTE_W-1:0]   sync_byte;
        logic [BYTE_W-1:0]   valid_code;
        logic [OFFSET_W-1:0] height_offset;
    } afd_cfg_t;

    typedef struct packed {
        logic signed [HEIGHT_W-1:0] height_dm;
        logic                       height_valid;
    } afd_res_t;

endpackage

[rtl/afd_if.sv]
// Valid/ready channel interfaces: received bytes, results and register writes.
interface afd_rx_if
    import afd_pkg::*;
    ;
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface afd_res_if
    import afd_pkg::*;
    ;
    logic                       valid;
    logic                       ready;
    logic signed [HEIGHT_W-1:0] height_dm;
    logic                       height_valid;

    modport source (output valid, output height_dm, output height_valid, input ready);
    modport sink   (input valid, input height_dm, input height_valid, output ready);
endinterface

interface afd_cfg_if
    import afd_pkg::*;
    ;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

[rtl/afd_window.sv]
// Six-byte window: holds five earlier bytes, checks for a frame, builds the result.
module afd_window
    import afd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  logic [BYTE_W-1:0] din,
    input  afd_cfg_t          cfg,
    output logic              hit,
    output afd_res_t          res
);

    logic [BYTE_W-1:0] bytes_reg [HELD];
    logic [BYTE_W-1:0] bytes_next [HELD];
    logic [FILL_W-1:0] fill_reg;
    logic [FILL_W-1:0] fill_next;

    logic                full;
    logic [BYTE_W+2:0]   sum;
    logic                match;
    logic [HEIGHT_W-1:0] diff;

    assign full = (fill_reg == FILL_FULL);
    assign sum  = (BYTE_W+3)'(bytes_reg[0]) + (BYTE_W+3)'(bytes_reg[1])
                + (BYTE_W+3)'(bytes_reg[2]) + (BYTE_W+3)'(bytes_reg[3])
                + (BYTE_W+3)'(bytes_reg[4]);
    assign match = (bytes_reg[0] == cfg.sync_byte) && (bytes_reg[1] == cfg.sync_byte)
                && (sum[BYTE_W-1:0] == din);
    assign hit = step && full && match;

    assign diff = {1'b0, bytes_reg[2], bytes_reg[3]} - {1'b0, cfg.height_offset};
    assign res.height_dm    = signed'(diff);
    assign res.height_valid = (bytes_reg[4] == cfg.valid_code);

    // Oldest byte sits at entry 0; filling and sliding are both a shift in at the top.
    always_comb
    begin
        bytes_next = bytes_reg;
        fill_next  = fill_reg;
        if (step)
        begin
            if (full && match)
            begin
                fill_next = '0;
            end
            else
            begin
                for (int i = 0; i < HELD - 1; i++)
                begin
                    bytes_next[i] = bytes_reg[i+1];
                end
                bytes_next[HELD-1] = din;
                if (!full)
                begin
                    fill_next = fill_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < HELD; i++)
            begin
                bytes_reg[i] <= '0;
            end
            fill_reg <= '0;
        end
        else
        begin
            bytes_reg <= bytes_next;
            fill_reg  <= fill_next;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n) fill_reg <= FILL_FULL)
        else $error("fill count above window size");

    assert property (@(posedge clk) disable iff (!rst_n) hit |=> fill_reg == '0)
        else $error("window not emptied after frame");

    assert property (@(posedge clk) disable iff (!rst_n)
        (step && !full) |=> fill_reg == $past(fill_reg) + 1'b1)
        else $error("fill count did not advance while filling");

endmodule

[rtl/altimeter_frame_deframer.sv]
// Top level of the altimeter frame deframer: byte input stage, window, result register.
// One received byte is accepted per cycle while the result register is not stalled. Each
// byte passes an input register and is checked against the five bytes held before it; a
// frame of sync, sync, data high, data low, status and checksum (low 8 bits of the sum of
// the first five) gives one result, height_dm = data - height_offset and height_valid =
// status matches valid_code, registered as the last byte leaves the input register. The
// result register holds an item until taken; while it is stalled one more byte waits in
// the input register, then input ready drops. Register writes are taken in any cycle and
// must come only while the block is idle.
module altimeter_frame_deframer
    import afd_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    afd_rx_if.sink    rx,
    afd_res_if.source res,
    afd_cfg_if.sink   cfg
);

    afd_cfg_t          cfg_reg;
    logic [BYTE_W-1:0] byte_reg;
    logic              byte_vld_reg;
    afd_res_t          res_reg;
    logic              res_vld_reg;

    logic     proceed;
    logic     hit;
    afd_res_t win_res;

    assign proceed  = byte_vld_reg && (!res_vld_reg || res.ready);
    assign rx.ready = !byte_vld_reg || proceed;
    assign cfg.ready = 1'b1;

    assign res.valid        = res_vld_reg;
    assign res.height_dm    = res_reg.height_dm;
    assign res.height_valid = res_reg.height_valid;

    afd_window u_window (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (proceed),
        .din   (byte_reg),
        .cfg   (cfg_reg),
        .hit   (hit),
        .res   (win_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.sync_byte     <= SYNC_BYTE_RST;
            cfg_reg.valid_code    <= VALID_CODE_RST;
            cfg_reg.height_offset <= HEIGHT_OFFSET_RST;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                REG_SYNC_BYTE:     cfg_reg.sync_byte     <= cfg.data[BYTE_W-1:0];
                REG_VALID_CODE:    cfg_reg.valid_code    <= cfg.data[BYTE_W-1:0];
                REG_HEIGHT_OFFSET: cfg_reg.height_offset <= cfg.data[OFFSET_W-1:0];
                default:           ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_vld_reg <= 1'b0;
            res_vld_reg  <= 1'b0;
        end
        else
        begin
            if (rx.valid && rx.ready)
            begin
                byte_vld_reg <= 1'b1;
            end
            else if (proceed)
            begin
                byte_vld_reg <= 1'b0;
            end

            if (hit)
            begin
                res_vld_reg <= 1'b1;
            end
            else if (res.ready)
            begin
                res_vld_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rx.valid && rx.ready)
        begin
            byte_reg <= rx.rx_byte;
        end
        if (hit)
        begin
            res_reg <= win_res;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        (rx.valid && rx.ready && byte_vld_reg) |-> proceed)
        else $error("pending byte overwritten");

    assert property (@(posedge clk) disable iff (!rst_n)
        hit |-> (!res_vld_reg || res.ready))
        else $error("result overwritten before taken");

    assert property (@(posedge clk) disable iff (!rst_n)
        (res_vld_reg && !res.ready) |=> res_vld_reg && $stable(res_reg))
        else $error("stalled result changed");

endmodule

[test/afd_frame_checker.sv]
`timescale 1ns / 1ps
// Frame checker: predicts deframer results from accepted bytes and compares each result item.
module afd_frame_checker
    import afd_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    afd_rx_if    rx,
    afd_res_if   res,
    afd_cfg_if   cfg,
    output int   fails,
    output int   pending,
    output int   checked
);

    logic [BYTE_W-1:0]   sync_q;
    logic [BYTE_W-1:0]   vcode_q;
    logic [OFFSET_W-1:0] offset_q;
    logic [BYTE_W-1:0]   window [HELD];
    int                  held_cnt;
    afd_res_t            heights_due [$];

    task automatic apply_write(input logic [CFG_IDX_W-1:0] idx,
                               input logic [CFG_DATA_W-1:0] d);
        case (idx)
            REG_SYNC_BYTE:     sync_q = d[BYTE_W-1:0];
            REG_VALID_CODE:    vcode_q = d[BYTE_W-1:0];
            REG_HEIGHT_OFFSET: offset_q = d[OFFSET_W-1:0];
            default: ;
        endcase
    endtask

    task automatic predict_byte(input logic [BYTE_W-1:0] b);
        logic [BYTE_W-1:0]   csum;
        logic [HEIGHT_W-1:0] raw;
        afd_res_t            r;
        if (held_cnt < HELD)
        begin
            window[held_cnt] = b;
            held_cnt++;
        end
        else
        begin
            csum = '0;
            for (int i = 0; i < HELD; i++)
                csum += window[i];
            if (window[0] == sync_q && window[1] == sync_q && csum == b)
            begin
                raw            = {1'b0, window[2], window[3]};
                r.height_dm    = raw - {1'b0, offset_q};
                r.height_valid = (window[4] == vcode_q);
                heights_due.push_back(r);
                held_cnt = 0;
            end
            else
            begin
                for (int i = 0; i < HELD - 1; i++)
                    window[i] = window[i + 1];
                window[HELD - 1] = b;
            end
        end
    endtask

    task automatic check_height;
        afd_res_t want;
        if (heights_due.size() == 0)
        begin
            $display("%0t: unexpected result item height_dm %0d height_valid %0b",
                     $time, res.height_dm, res.height_valid);
            fails++;
        end
        else
        begin
            want = heights_due.pop_front();
            checked++;
            if (want.height_dm !== res.height_dm)
            begin
                $display("%0t: height_dm expected %0d, got %0d",
                         $time, want.height_dm, res.height_dm);
                fails++;
            end
            if (want.height_valid !== res.height_valid)
            begin
                $display("%0t: height_valid expected %0b, got %0b",
                         $time, want.height_valid, res.height_valid);
                fails++;
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sync_q   = SYNC_BYTE_RST;
            vcode_q  = VALID_CODE_RST;
            offset_q = HEIGHT_OFFSET_RST;
            for (int i = 0; i < HELD; i++)
                window[i] = '0;
            held_cnt = 0;
            heights_due.delete();
            fails   = 0;
            checked = 0;
        end
        else
        begin
            if (res.valid && res.ready)
                check_height();
            if (cfg.valid && cfg.ready)
                apply_write(cfg.index, cfg.data);
            if (rx.valid && rx.ready)
                predict_byte(rx.rx_byte);
        end
        pending = heights_due.size();
    end

endmodule

[test/altimeter_frame_deframer_tb.sv]
`timescale 1ns / 1ps
// Testbench top: clock, reset, byte and register stimulus, and the final verdict.
module altimeter_frame_deframer_tb;
    import afd_pkg::*;

    // index past the register list; writes to it must be ignored
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    afd_rx_if  rx();
    afd_res_if res();
    afd_cfg_if cfg();

    int fails;
    int pending;
    int checked;

    int snd_idle_pct = 0;
    int rcv_idle_pct = 0;
    int bytes_sent = 0;
    int settings_used = 1;

    logic [BYTE_W-1:0] cur_sync = SYNC_BYTE_RST;
    logic [BYTE_W-1:0] cur_valid = VALID_CODE_RST;

    altimeter_frame_deframer DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .rx    (rx),
        .res   (res),
        .cfg   (cfg)
    );

    afd_frame_checker frame_chk (
        .clk     (clk),
        .rst_n   (rst_n),
        .rx      (rx),
        .res     (res),
        .cfg     (cfg),
        .fails   (fails),
        .pending (pending),
        .checked (checked)
    );

    always #10 clk = ~clk;

    always @(negedge clk)
        res.ready <= ($urandom_range(0, 99) >= rcv_idle_pct);

    // called at a falling edge, returns at a falling edge with the item taken
    task automatic send_byte(input logic [BYTE_W-1:0] b);
        while ($urandom_range(0, 99) < snd_idle_pct)
        begin
            rx.valid <= 1'b0;
            @(negedge clk);
        end
        rx.valid   <= 1'b1;
        rx.rx_byte <= b;
        @(posedge clk);
        while (!rx.ready)
            @(posedge clk);
        bytes_sent++;
        @(negedge clk);
    endtask

    task automatic send_frame(input logic [BYTE_W-1:0] hi, input logic [BYTE_W-1:0] lo,
                              input logic [BYTE_W-1:0] status, input bit corrupt);
        logic [BYTE_W-1:0] f [6];
        int                k;
        f[0] = cur_sync;
        f[1] = cur_sync;
        f[2] = hi;
        f[3] = lo;
        f[4] = status;
        f[5] = f[0] + f[1] + f[2] + f[3] + f[4];
        if (corrupt)
        begin
            k = $urandom_range(0, 5);
            f[k] = f[k] ^ BYTE_W'($urandom_range(1, 255));
        end
        for (int i = 0; i < 6; i++)
            send_byte(f[i]);
    endtask

    // input goes quiet until every expected result item has come out
    task automatic settle;
        rx.valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] d);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data  <= d;
        @(posedge clk);
        while (!cfg.ready)
            @(posedge clk);
        case (idx)
            REG_SYNC_BYTE:  cur_sync = d[BYTE_W-1:0];
            REG_VALID_CODE: cur_valid = d[BYTE_W-1:0];
            default: ;
        endcase
        @(negedge clk);
        cfg.valid <= 1'b0;
        @(negedge clk);
    endtask

    task automatic random_traffic(input int n);
        int                stop_at;
        int                r;
        logic [BYTE_W-1:0] hi;
        logic [BYTE_W-1:0] lo;
        logic [BYTE_W-1:0] status;
        stop_at = bytes_sent + n;
        while (bytes_sent < stop_at)
        begin
            r = $urandom_range(0, 99);
            if (r < 82)
            begin
                case ($urandom_range(0, 9))
                    0:       {hi, lo} = 16'h0000;
                    1:       {hi, lo} = 16'hFFFF;
                    default: {hi, lo} = 16'($urandom_range(0, 65535));
                endcase
                status = $urandom_range(0, 1) ? cur_valid : BYTE_W'($urandom_range(0, 255));
                send_frame(hi, lo, status, r >= 70);
            end
            else
            begin
                repeat ($urandom_range(1, 3))
                    send_byte(BYTE_W'($urandom_range(0, 255)));
            end
            if ($urandom_range(0, 199) == 0)
                settle();
        end
    endtask

    initial
    begin
        rx.valid   = 1'b0;
        rx.rx_byte = '0;
        cfg.valid  = 1'b0;
        cfg.index  = REG_SYNC_BYTE;
        cfg.data   = '0;
        res.ready  = 1'b0;
        repeat (6) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed: largest height, negative height with bad status, one byte of
        // slide before a frame, then a frame with a damaged byte
        send_frame(8'hFF, 8'hFF, cur_valid, 1'b0);
        send_frame(8'h00, 8'h00, 8'h00, 1'b0);
        send_byte(8'h00);
        send_frame(8'h12, 8'h34, cur_valid, 1'b0);
        send_frame(8'hA5, 8'h5A, cur_valid, 1'b1);

        for (int p = 0; p < 3; p++)
        begin
            case (p)
                0:
                begin
                    snd_idle_pct = 32;
                    rcv_idle_pct = 48;
                end
                1:
                begin
                    snd_idle_pct = 48;
                    rcv_idle_pct = 32;
                end
                default:
                begin
                    snd_idle_pct = 0;
                    rcv_idle_pct = 0;
                end
            endcase
            for (int h = 0; h < 2; h++)
            begin
                settle();
                case (p * 2 + h)
                    0:
                    begin
                        // upper data bits must not reach the 8-bit registers
                        cfg_write(REG_SYNC_BYTE, 16'hA500);
                        cfg_write(REG_VALID_CODE, 16'h00FF);
                        cfg_write(REG_HEIGHT_OFFSET, 16'h0000);
                        cfg_write(REG_SPARE, 16'h0011);
                    end
                    1:
                    begin
                        cfg_write(REG_SYNC_BYTE, 16'h00FF);
                        cfg_write(REG_VALID_CODE, 16'hFF00);
                        cfg_write(REG_HEIGHT_OFFSET, 16'hFFFF);
                    end
                    default:
                    begin
                        cfg_write(REG_SYNC_BYTE, 16'($urandom_range(0, 65535)));
                        cfg_write(REG_VALID_CODE, 16'($urandom_range(0, 65535)));
                        cfg_write(REG_HEIGHT_OFFSET, 16'($urandom_range(0, 65535)));
                    end
                endcase
                settings_used++;
                random_traffic(265);
            end
        end

        settle();
        repeat (6) @(negedge clk);
        $display("Ran %0d bytes and checked %0d height results over %0d register settings,",
                 bytes_sent, checked, settings_used);
        $display("with sender gaps, receiver stalls and a stretch without either.");
        if (fails == 0 && pending == 0)
            $display("altimeter_frame_deframer test passed");
        else
            $display("altimeter_frame_deframer test failed");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("altimeter_frame_deframer test failed");
        $finish;
    end

endmodule
